>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the hash table RTL.
// Depends on signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HTQP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HTQP_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HTQP_ASSERT(lbl, prop, msg)
`define HTQP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/htqp_pkg.sv
// Types, constants and codes of the quadratic-probing hash table.
// Used by the controller, the datapath and the top level.
package htqp_pkg;

   // The table size must be a power of two so that slot arithmetic wraps.
   localparam int TABLE_SIZE = 16;
   localparam int KEY_WIDTH  = 16;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);
   localparam int COUNT_W    = $clog2(TABLE_SIZE + 1);

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_DELETE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_USED    = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic finish;
   } dp_status_type;

endpackage

>>> hw/rtl/htqp_ctrl.sv
// Controller of the hash table: command sequencing and result handshake.
// Depends on htqp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module htqp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  htqp_pkg::dp_status_type status,
   output htqp_pkg::ctrl_cmd_type  cmd
);
   import htqp_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_PROBE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.load   = req_valid && (state_ff == S_IDLE);
      cmd.step   = (state_ff == S_PROBE) && !status.finish;
      cmd.commit = (state_ff == S_PROBE) && status.finish && out_free;
      state_in   = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (cmd.commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `HTQP_ASSERT(a_commit_shows_result, cmd.commit |=> rsp_valid_ff, "commit lost its result")
   `HTQP_ASSERT(a_commit_frees_input, cmd.commit |=> req_ready, "input not freed after commit")
   `HTQP_ASSERT(a_load_starts_probe, cmd.load |=> !req_ready, "no probe after load")
   `HTQP_ASSERT_RST(a_no_step_and_commit, reset || !(cmd.step && cmd.commit), "step with commit")

endmodule

>>> hw/rtl/htqp_datapath.sv
// Datapath of the hash table: command registers, probe sequence, slot stores
// and the result register. Depends on htqp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module htqp_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  htqp_pkg::ctrl_cmd_type        cmd,
   output htqp_pkg::dp_status_type       status,
   input  logic [1:0]                    req_action,
   input  logic [15:0]                   req_key,
   output logic [1:0]                    rsp_status,
   output logic [htqp_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic [htqp_pkg::COUNT_W-1:0]  rsp_collisions
);
   import htqp_pkg::*;

   action_type           action_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [SLOT_W-1:0]    delta_ff, delta_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [KEY_WIDTH-1:0] keys_ff [TABLE_SIZE];
   mark_type             marks_ff [TABLE_SIZE];

   status_type           res_status_ff, res_status;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot;
   logic [COUNT_W-1:0]   res_coll_ff, res_coll;

   mark_type             cur_mark;
   mark_type             new_mark;
   logic                 hit;
   logic                 exhausted;
   logic                 finish;
   logic                 wr_key;
   logic                 wr_mark;

   assign cur_mark  = marks_ff[slot_ff];
   assign hit       = (cur_mark == MARK_USED) && (keys_ff[slot_ff] == key_ff);
   assign exhausted = (count_ff == COUNT_W'(TABLE_SIZE));

   always_comb begin
      finish     = 1'b0;
      res_status = ST_MISSING;
      res_slot   = '0;
      res_coll   = count_ff;
      wr_key     = 1'b0;
      wr_mark    = 1'b0;
      new_mark   = MARK_USED;
      case (action_ff)
         ACT_INSERT: begin
            if (exhausted) begin
               finish     = 1'b1;
               res_status = ST_FULL;
            end else if (cur_mark != MARK_USED) begin
               finish     = 1'b1;
               res_status = ST_DONE;
               res_slot   = slot_ff;
               wr_key     = 1'b1;
               wr_mark    = 1'b1;
            end
         end
         ACT_SEARCH, ACT_DELETE: begin
            if (exhausted || cur_mark == MARK_EMPTY) begin
               finish = 1'b1;
            end else if (hit) begin
               finish     = 1'b1;
               res_status = ST_DONE;
               res_slot   = slot_ff;
               wr_mark    = (action_ff == ACT_DELETE);
               new_mark   = MARK_DELETED;
            end
         end
         default: begin
            finish   = 1'b1;
            res_coll = '0;
         end
      endcase
   end

   assign status.finish = finish;

   // Probe i visits home + i*i; successive offsets differ by 2i+1.
   always_comb begin
      slot_in  = slot_ff;
      delta_in = delta_ff;
      count_in = count_ff;
      if (cmd.load) begin
         slot_in  = req_key[SLOT_W-1:0];
         delta_in = SLOT_W'(1);
         count_in = '0;
      end else if (cmd.step) begin
         slot_in  = slot_ff + delta_ff;
         delta_in = delta_ff + SLOT_W'(2);
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= action_type'(req_action);
         key_ff    <= req_key[KEY_WIDTH-1:0];
      end
      slot_ff  <= slot_in;
      delta_ff <= delta_in;
      count_ff <= count_in;
      if (cmd.commit) begin
         res_status_ff <= res_status;
         res_slot_ff   <= res_slot;
         res_coll_ff   <= res_coll;
      end
      if (cmd.commit && wr_key) begin
         keys_ff[slot_ff] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            marks_ff[i] <= MARK_EMPTY;
         end
      end else if (cmd.commit && wr_mark) begin
         marks_ff[slot_ff] <= new_mark;
      end
   end

   assign rsp_status     = res_status_ff;
   assign rsp_slot_index = res_slot_ff;
   assign rsp_collisions = res_coll_ff;

   `HTQP_ASSERT(a_count_bounded, cmd.step |-> !exhausted, "probe ran past the table size")
   `HTQP_ASSERT(a_step_counts, cmd.step |=> (count_ff == $past(count_ff) + COUNT_W'(1)), "probe count skipped")

endmodule

>>> hw/rtl/hash_table_quadratic_probe.sv
// Top level of the open-addressing hash table with quadratic probing.
// Depends on htqp_pkg, htqp_ctrl and htqp_datapath.
//
//   Channel  Handshake              Payload
//   req      req_valid/req_ready    req_action, req_key
//   rsp      rsp_valid/rsp_ready    rsp_status, rsp_slot_index, rsp_collisions
//
// A command is first loaded and then probes one slot at a time, plus a final check that
// sees the probe count run out after TABLE_SIZE probes have found no place; the probe
// loop reads one slot mark and key a cycle.
// Reset clears all slot marks at once; no clearing pass follows.
// While the result register still holds an untaken result, the final probe holds.
// A new command is taken once the previous one has been committed to that register.
module hash_table_quadratic_probe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_action,
   input  logic [15:0]                   req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [htqp_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic [htqp_pkg::COUNT_W-1:0]  rsp_collisions
);
   import htqp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   htqp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   htqp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_key        (req_key),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_collisions (rsp_collisions)
   );

endmodule
